// ===== hdl/ccmp_pkg.sv =====
// shared types, tables and helpers for the ccmp counter-mode decryptor
package ccmp_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam logic [3:0] SETTLE_CYCLES = 4'd11;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // item travelling down the round chain
  typedef struct packed {
    logic         vld;
    logic [127:0] blk;    // cipher state, byte 0 in the top bits
    logic [127:0] ct;     // ciphertext carried alongside
    logic [4:0]   nbytes; // already clamped to 1..16
    logic         last;
  } ccmp_item_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== hdl/ccmp_round_cell.sv =====
// one aes round with its own round key register, a link of the round chain
module ccmp_round_cell import ccmp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         last_rnd,
  input  logic [7:0]   rcon,
  input  logic [127:0] rk_prev,
  input  ccmp_item_t   item_in,
  output logic [127:0] rk,
  output ccmp_item_t   item_out
);

  logic [127:0] rk_r;
  logic [127:0] rk_nxt;
  ccmp_item_t   item_r;
  logic [127:0] blk_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];

  // key schedule step from the previous round key
  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk_prev[127:96];
    w1 = rk_prev[95:64];
    w2 = rk_prev[63:32];
    w3 = rk_prev[31:0];
    t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    rk_nxt = {w0, w1, w2, w3};
  end

  always_comb begin
    logic [7:0] all;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[item_in.blk[127 - 8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[i + 4*c] = sb[i + 4*((c + i) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c]   = sr[4*c]   ^ all ^ xtime(sr[4*c]   ^ sr[4*c+1]);
      mc[4*c+1] = sr[4*c+1] ^ all ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
      mc[4*c+2] = sr[4*c+2] ^ all ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
      mc[4*c+3] = sr[4*c+3] ^ all ^ xtime(sr[4*c+3] ^ sr[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      blk_nxt[127 - 8*i -: 8] = (last_rnd ? sr[i] : mc[i]) ^ rk_r[127 - 8*i -: 8];
    end
  end

  always_ff @(posedge clk) begin
    rk_r <= rk_nxt;
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r.vld    <= item_in.vld;
      item_r.blk    <= blk_nxt;
      item_r.ct     <= item_in.ct;
      item_r.nbytes <= item_in.nbytes;
      item_r.last   <= item_in.last;
    end
  end

  assign rk       = rk_r;
  assign item_out = item_r;

endmodule

// ===== hdl/ccmp_ctr_payload_decrypt_unit.sv =====
// top level: ccmp counter-mode payload decryptor, aes-128 round chain
// registers from data transfer in to result valid: entry stage, ten rounds, output
// throughput: one item per cycle when not stalled; headers leave a bubble, no result
// reset: synchronous active low, clears key, packet number, address, index and pipe valids
// after reset or a key write in_tready stays low while the round key chain settles
module ccmp_ctr_payload_decrypt_unit import ccmp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // transmitter[47:0], ccmp_header[111:48], data_high[175:112], data_low[239:176],
  // valid_bytes[244:240], zero pad [247:245]
  input  logic [247:0] in_tdata,
  input  logic         in_tuser,   // action
  input  logic         in_tlast,   // final_block
  output logic         out_tvalid,
  input  logic         out_tready,
  // plain_high[63:0], plain_low[127:64], out_bytes[132:128], zero pad [135:133]
  output logic [135:0] out_tdata,
  output logic         out_tlast,  // out_last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam logic [7:0] CFG_KEY_HIGH = 8'd0;
  localparam logic [7:0] CFG_KEY_LOW  = 8'd1;

  logic [63:0]  key_high_r, key_low_r;
  logic [47:0]  pn_r, addr_r;
  logic [15:0]  idx_r;
  logic [3:0]   settle_r;
  logic         en;
  logic         in_xfer;
  logic [4:0]   vb;
  logic [4:0]   nb;
  logic [127:0] ctr_blk;
  ccmp_item_t   stage0_r;
  ccmp_item_t   chain [NUM_ROUNDS+1];
  logic [127:0] rkey  [NUM_ROUNDS+1];
  logic [127:0] ks_ct;
  logic [127:0] plain;
  logic         out_valid_r;
  logic [127:0] plain_r;
  logic [4:0]   out_n_r;
  logic         out_last_r;

  // whole chain moves together whenever the output register can take data
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && (settle_r == 4'd0);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // byte count of zero or above sixteen means a full block
  assign vb = in_tdata[244:240];
  assign nb = (vb == 5'd0 || vb > 5'd16) ? 5'd16 : vb;

  assign ctr_blk = {8'h01, 8'h00, addr_r, pn_r, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      pn_r       <= '0;
      addr_r     <= '0;
      idx_r      <= '0;
      settle_r   <= SETTLE_CYCLES;
      stage0_r.vld <= 1'b0;
    end else begin
      // key write restarts the settle window for the round key chain
      if (cfg_valid && cfg_index == CFG_KEY_HIGH) begin
        key_high_r <= cfg_data;
        settle_r   <= SETTLE_CYCLES;
      end else if (cfg_valid && cfg_index == CFG_KEY_LOW) begin
        key_low_r  <= cfg_data;
        settle_r   <= SETTLE_CYCLES;
      end else if (settle_r != 4'd0) begin
        settle_r <= settle_r - 4'd1;
      end
      // header transfer loads address and packet number (header bytes 7,6,5,4,1,0)
      if (in_xfer && !in_tuser) begin
        addr_r <= in_tdata[47:0];
        pn_r   <= {in_tdata[111:80], in_tdata[63:48]};
        idx_r  <= 16'd1;
      end else if (in_xfer) begin
        idx_r <= idx_r + 16'd1;
      end
      if (en) begin
        stage0_r.vld    <= in_xfer && in_tuser;
        stage0_r.blk    <= ctr_blk ^ {key_high_r, key_low_r};
        stage0_r.ct     <= {in_tdata[175:112], in_tdata[239:176]};
        stage0_r.nbytes <= nb;
        stage0_r.last   <= in_tlast;
      end
    end
  end

  assign chain[0] = stage0_r;
  assign rkey[0]  = {key_high_r, key_low_r};

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    ccmp_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .last_rnd (r == NUM_ROUNDS),
      .rcon     (RCON[r-1]),
      .rk_prev  (rkey[r-1]),
      .item_in  (chain[r-1]),
      .rk       (rkey[r]),
      .item_out (chain[r])
    );
  end

  // keystream xor over the leading valid bytes, the rest forced to zero
  assign ks_ct = chain[NUM_ROUNDS].blk ^ chain[NUM_ROUNDS].ct;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      plain[127 - 8*i -: 8] = (5'(i) < chain[NUM_ROUNDS].nbytes) ?
                              ks_ct[127 - 8*i -: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[NUM_ROUNDS].vld;
      plain_r     <= plain;
      out_n_r     <= chain[NUM_ROUNDS].nbytes;
      out_last_r  <= chain[NUM_ROUNDS].last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_n_r, plain_r[63:0], plain_r[127:64]};
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/ccmp_checker.sv =====
// port-level checks for the ccmp decryptor, bound to the top level
module ccmp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic         cfg_valid,
  input logic [7:0]   cfg_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[132:128] != 5'd0 && out_tdata[132:128] <= 5'd16
                   && out_tdata[135:133] == 3'b000)
    else $error("bad byte count or padding");

  a_key_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && (cfg_index == 8'd0 || cfg_index == 8'd1) |=> !in_tready)
    else $error("input taken while round keys settle");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind ccmp_ctr_payload_decrypt_unit ccmp_checker u_ccmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_index  (cfg_index)
);

// ===== tb/tb_ccmp_ctr_payload_decrypt_unit.sv =====
// testbench for the ccmp counter-mode payload decryptor with a behavioral aes-128 predictor
`timescale 1ns / 100ps

module tb_ccmp_ctr_payload_decrypt_unit;
  import ccmp_pkg::*;

  localparam logic [7:0] REG_KEY_HIGH = 8'd0;
  localparam logic [7:0] REG_KEY_LOW  = 8'd1;
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_DATA   = 1'b1;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic         action;
    logic [47:0]  transmitter;
    logic [63:0]  ccmp_header;
    logic [63:0]  data_high;
    logic [63:0]  data_low;
    logic [4:0]   valid_bytes;
    logic         final_block;
  } frame_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  out_bytes;
    logic        out_last;
  } plain_block_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [247:0] in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [63:0]  cfg_data;

  ccmp_ctr_payload_decrypt_unit dut (.*);

  // the testbench's own sbox, built from field inversion and the affine map
  logic [7:0] sub_tab [256];

  // predictor state
  logic [63:0]  key_hi_m, key_lo_m;
  logic [47:0]  pn_m, addr_m;
  logic [15:0]  idx_m;
  logic [127:0] rkeys [11];

  frame_item_t  item_q [$];
  plain_block_t plain_q [$];
  int errors;
  int cycles;
  int rx_wait;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  initial begin
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256; y++)
        if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      sub_tab[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                   ^ 8'h63;
    end
  end

  // round keys as 128-bit words, byte 0 in the top bits
  task automatic build_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi_m, key_lo_m};
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sub_tab[t[23:16]] ^ rc, sub_tab[t[15:8]], sub_tab[t[7:0]], sub_tab[t[31:24]]};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] aes_block(logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rkeys[0][127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) t[i] = sub_tab[s[i]];
      // shift rows: byte i of column c comes from column c+i
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) s[i+4*c] = t[i + 4*((c+i) % 4)];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          s[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
          s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
          s[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rkeys[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) pt[127-8*i -: 8] = s[i];
    return pt;
  endfunction

  // append one pending item for the driver
  task automatic queue_item(frame_item_t it);
    item_q.insert(item_q.size(), it);
  endtask

  // advance the frame state and queue the plaintext a data transfer yields
  task automatic predict_plaintext(frame_item_t it);
    logic [127:0] ks, ct, pt;
    int n;
    plain_block_t exp_blk;
    if (it.action == ACT_HEADER) begin
      addr_m = it.transmitter;
      pn_m = {it.ccmp_header[63:32], it.ccmp_header[15:8], it.ccmp_header[7:0]};
      idx_m = 16'd1;
    end else begin
      ks = aes_block({8'h01, 8'h00, addr_m, pn_m, idx_m});
      ct = {it.data_high, it.data_low};
      n = it.valid_bytes;
      if (n == 0 || n > 16) n = 16;
      for (int i = 0; i < 16; i++)
        pt[127-8*i -: 8] = (i < n) ? (ct[127-8*i -: 8] ^ ks[127-8*i -: 8]) : 8'h00;
      idx_m = idx_m + 16'd1;
      exp_blk.plain_high = pt[127:64];
      exp_blk.plain_low = pt[63:0];
      exp_blk.out_bytes = 5'(n);
      exp_blk.out_last = it.final_block;
      plain_q.insert(plain_q.size(), exp_blk);
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("ccmp_ctr_payload_decrypt_unit test failed");
      $finish;
    end
  end

  // driver: one pending transfer at a time, random gap before each
  int tx_wait;
  bit drv_busy;
  bit hold_tx;
  frame_item_t cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      drv_busy = 0;
      tx_wait = 0;
    end else begin
      if (drv_busy && in_tvalid && in_tready) begin
        predict_plaintext(cur);
        drv_busy = 0;
        tx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (!drv_busy && !hold_tx && item_q.size() > 0) begin
        if (tx_wait > 0) tx_wait--;
        else begin
          cur = item_q.pop_front();
          drv_busy = 1;
        end
      end
      in_tvalid <= drv_busy;
      if (drv_busy) begin
        in_tdata <= {3'b000, cur.valid_bytes, cur.data_low, cur.data_high,
                     cur.ccmp_header, cur.transmitter};
        in_tuser <= cur.action;
        in_tlast <= cur.final_block;
      end
    end
  end

  // monitor: compare each result transfer with the oldest expected block, random stalls
  plain_block_t got_blk, want_blk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_blk = {out_tdata[63:0], out_tdata[127:64], out_tdata[132:128], out_tlast};
        if (plain_q.size() == 0) report("unexpected result", got_blk.plain_high, 64'd0);
        else begin
          want_blk = plain_q.pop_front();
          if (got_blk.plain_high !== want_blk.plain_high)
            report("plain_high", got_blk.plain_high, want_blk.plain_high);
          if (got_blk.plain_low !== want_blk.plain_low)
            report("plain_low", got_blk.plain_low, want_blk.plain_low);
          if (got_blk.out_bytes !== want_blk.out_bytes)
            report("out_bytes", 64'(got_blk.out_bytes), 64'(want_blk.out_bytes));
          if (got_blk.out_last !== want_blk.out_last)
            report("out_last", 64'(got_blk.out_last), 64'(want_blk.out_last));
        end
        rx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 0;
      end else out_tready <= 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic frame_item_t header_item(logic [47:0] ta, logic [63:0] hdr);
    frame_item_t it;
    it = '0;
    it.action = ACT_HEADER;
    it.transmitter = ta;
    it.ccmp_header = hdr;
    // data fields carry junk, the block must ignore them
    it.data_high = rand64();
    it.data_low = rand64();
    it.valid_bytes = 5'($urandom());
    it.final_block = 1'($urandom());
    return it;
  endfunction

  function automatic frame_item_t data_item(logic [4:0] nb, logic fin);
    frame_item_t it;
    it.action = ACT_DATA;
    it.transmitter = 48'(rand64());
    it.ccmp_header = rand64();
    it.data_high = rand64();
    it.data_low = rand64();
    it.valid_bytes = nb;
    it.final_block = fin;
    return it;
  endfunction

  // block until every queued item is sent and every result is in, then let the pipe drain
  task automatic quiesce();
    while (item_q.size() > 0 || drv_busy || plain_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(logic [7:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_KEY_HIGH) key_hi_m = val;
    else if (idx == REG_KEY_LOW) key_lo_m = val;
    build_round_keys();
  endtask

  task automatic random_frames(int total);
    int sent, nblk;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: a stray data item or a header without data
        if ($urandom_range(0, 1)) queue_item(data_item(5'($urandom()), 1'($urandom())));
        else queue_item(header_item(48'(rand64()), rand64()));
        sent++;
      end else begin
        queue_item(header_item(48'(rand64()), rand64()));
        nblk = $urandom_range(1, 12);
        for (int b = 0; b < nblk; b++)
          queue_item(data_item(b == nblk - 1 ? 5'($urandom_range(1, 16)) : 5'd16,
                               b == nblk - 1));
        sent += nblk + 1;
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_tx = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    in_tlast = 0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    key_hi_m = 0;
    key_lo_m = 0;
    pn_m = 0;
    addr_m = 0;
    idx_m = 0;
    repeat (10) @(posedge clk);
    build_round_keys();
    rst_n <= 1;
    @(posedge clk);

    // data before any header, under the reset key
    queue_item(data_item(5'd16, 0));
    queue_item(data_item(5'd0, 0));
    queue_item(data_item(5'd31, 1));
    queue_item(data_item(5'd17, 0));
    // extremes of the header fields, byte counts 1, 15, 8, 9 and the even counts 2 to 16
    queue_item(header_item('1, '1));
    queue_item(data_item(5'd1, 0));
    queue_item(data_item(5'd15, 1));
    queue_item(header_item('0, '0));
    queue_item(data_item(5'd8, 0));
    queue_item(data_item(5'd9, 1));
    queue_item(header_item(48'h0123456789ab, 64'h0123456789abcdef));
    for (int n = 2; n <= 16; n += 2) queue_item(data_item(5'(n), n == 16));
    quiesce();

    // all-ones key, then a write to an index beyond the list
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    write_key(8'd7, rand64());
    queue_item(header_item(48'(rand64()), rand64()));
    random_frames(300);
    quiesce();

    // frames with the low key word zero
    write_key(REG_KEY_HIGH, rand64());
    write_key(REG_KEY_LOW, 64'h0);
    queue_item(header_item(48'(rand64()), rand64()));
    random_frames(200);
    // pause the sender until every result has come
    hold_tx = 1;
    while (drv_busy || plain_q.size() > 0) @(posedge clk);
    hold_tx = 0;
    quiesce();

    for (int ph = 0; ph < 4; ph++) begin
      write_key(REG_KEY_HIGH, rand64());
      write_key(REG_KEY_LOW, rand64());
      random_frames(360);
      quiesce();
    end

    if (errors == 0) begin
      $display("ccmp_ctr_payload_decrypt_unit test passed");
    end else begin
      $display("ccmp_ctr_payload_decrypt_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ccmp_pkg.sv
hdl/ccmp_round_cell.sv
hdl/ccmp_ctr_payload_decrypt_unit.sv
hdl/ccmp_checker.sv
tb/tb_ccmp_ctr_payload_decrypt_unit.sv
